>>> design/authorized_tag_toggle_table_unit_assert.svh
// ----------------------------------------------------------------------------
// authorized tag toggle table: assertion macros
// clocked on i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef AUTHORIZED_TAG_TOGGLE_TABLE_UNIT_ASSERT_SVH
`define AUTHORIZED_TAG_TOGGLE_TABLE_UNIT_ASSERT_SVH

// condition holds at every edge
`define ATTT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ATTT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ATTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/attt_pkg.sv
// ----------------------------------------------------------------------------
// attt_pkg
// types and constants of the authorized tag toggle table
// ----------------------------------------------------------------------------
package attt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int UID_BITS    = 56;

    // field widths of the words on the ports
    localparam int MODE_W     = 2;
    localparam int FIELD_UID_W = 56;
    localparam int STATUS_W   = 4;
    localparam int ENTRY_W    = 5;
    localparam int MASTER_W   = 56;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MASTER_W;

    localparam int IN_FIELDS_W  = MODE_W + 2 * FIELD_UID_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + ENTRY_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // table indexing
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_TOGGLE = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_ALT_LOOKUP = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ADDED   = 4'd0,
        STAT_REMOVED = 4'd1,
        STAT_FOUND   = 4'd2,
        STAT_ABSENT  = 4'd3,
        STAT_UNCONF  = 4'd4,
        STAT_BAD_ADMIN = 4'd5,
        STAT_MASTER  = 4'd6,
        STAT_FULL    = 4'd7,
        STAT_CLEARED = 4'd8
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASTER_UID     = 1'b0,
        CFG_SYS_CONFIGURED = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_RESP
    } t_state;

endpackage

>>> design/authorized_tag_toggle_table_unit.sv
// ----------------------------------------------------------------------------
// authorized_tag_toggle_table_unit: table of authorized tag identifiers
// refused toggles and clears skip the search; lookups, appends and removals scan the
// stored entries, and a removal then shifts the entries above the hit down one slot
// one request at a time, set by the single read port of the tag ram
// synchronous active-low reset empties the table and clears both registers
// ----------------------------------------------------------------------------
module authorized_tag_toggle_table_unit
    import attt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // request stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // mode, admin_uid, tag_uid, zero pad
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // status, entry_count, zero pad
);

    // registers written through the configuration port
    logic [MASTER_W-1:0] r_master_uid;
    logic                r_sys_cfg;

    // control
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_idx, n_idx;           // next entry to read
    logic               r_pend_vld, n_pend_vld; // a ram read is in flight
    logic [CNT_W-1:0]   r_pend_idx, n_pend_idx; // entry of that read
    logic [CNT_W-1:0]   r_count, n_count;       // number of stored tags
    logic               r_is_toggle, n_is_toggle;
    logic [UID_BITS-1:0] r_tag, n_tag;
    t_status            r_status, n_status;

    // output register, lets the next request in while a result waits
    logic               r_out_vld;
    t_status            r_out_status;
    logic [CNT_W-1:0]   r_out_count;

    // ram ports
    logic                ram_we, ram_re;
    logic [IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [UID_BITS-1:0] ram_wdata, ram_rdata;

    logic                s_fire;
    logic                out_load;
    t_mode               in_mode;
    logic [UID_BITS-1:0] in_admin, in_tag, master;
    logic                hit;
    logic [CNT_W-1:0]    shift_dst;

    // word decode
    assign in_mode  = t_mode'(i_s_axis_tdata[MODE_W-1:0]);
    assign in_admin = UID_BITS'(i_s_axis_tdata[MODE_W +: FIELD_UID_W]);
    assign in_tag   = UID_BITS'(i_s_axis_tdata[MODE_W + FIELD_UID_W +: FIELD_UID_W]);
    assign master   = UID_BITS'(r_master_uid);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    // compare stage of the search
    assign hit       = r_pend_vld && (ram_rdata == r_tag);
    assign shift_dst = r_pend_idx - CNT_W'(1);

    assign out_load = (r_state == ST_RESP) && (!r_out_vld || i_m_axis_tready);

    attt_ram #(
        .WIDTH (UID_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    priority if (in_mode == MODE_CLEAR) begin
                        n_state = ST_RESP;
                    end else if (in_mode == MODE_TOGGLE &&
                                 (!r_sys_cfg || in_admin != master || in_tag == master)) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                priority if (hit) begin
                    n_state = r_is_toggle ? ST_SHIFT : ST_RESP;
                end else if (r_idx < r_count) begin
                    n_state = ST_SEARCH;
                end else if (!r_pend_vld) begin
                    n_state = ST_RESP;
                end else begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SHIFT: begin
                if (!r_pend_vld && r_idx >= r_count) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_idx       = r_idx;
        n_pend_vld  = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_count     = r_count;
        n_is_toggle = r_is_toggle;
        n_tag       = r_tag;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = r_count[IDX_W-1:0];
        ram_wdata   = r_tag;
        ram_re      = 1'b0;
        ram_raddr   = r_idx[IDX_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    n_idx       = '0;
                    n_tag       = in_tag;
                    n_is_toggle = (in_mode == MODE_TOGGLE);
                    // clear, then lookup, then the toggle refusals in their fixed order
                    priority if (in_mode == MODE_CLEAR) begin
                        n_count  = '0;
                        n_status = STAT_CLEARED;
                    end else if (in_mode != MODE_TOGGLE) begin
                        n_status = STAT_ABSENT;
                    end else if (!r_sys_cfg) begin
                        n_status = STAT_UNCONF;
                    end else if (in_admin != master) begin
                        n_status = STAT_BAD_ADMIN;
                    end else if (in_tag == master) begin
                        n_status = STAT_MASTER;
                    end else begin
                        n_status = STAT_ADDED;
                    end
                end
            end
            ST_SEARCH: begin
                priority if (hit) begin
                    // removal starts with the entry above the hit
                    n_idx    = r_pend_idx + CNT_W'(1);
                    n_status = r_is_toggle ? STAT_REMOVED : STAT_FOUND;
                end else if (r_idx < r_count) begin
                    ram_re     = 1'b1;
                    n_pend_vld = 1'b1;
                    n_pend_idx = r_idx;
                    n_idx      = r_idx + CNT_W'(1);
                end else if (!r_pend_vld) begin
                    // search exhausted, tag is absent
                    if (!r_is_toggle) begin
                        n_status = STAT_ABSENT;
                    end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                        n_status = STAT_FULL;
                    end else begin
                        ram_we   = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                        n_status = STAT_ADDED;
                    end
                end
            end
            ST_SHIFT: begin
                // read entry j while writing entry j-1 read the cycle before
                if (r_pend_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = shift_dst[IDX_W-1:0];
                    ram_wdata = ram_rdata;
                end
                if (r_idx < r_count) begin
                    ram_re     = 1'b1;
                    n_pend_vld = 1'b1;
                    n_pend_idx = r_idx;
                    n_idx      = r_idx + CNT_W'(1);
                end else if (!r_pend_vld) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_vld   <= 1'b0;
            r_count      <= '0;
            r_out_vld    <= 1'b0;
            r_master_uid <= '0;
            r_sys_cfg    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_count    <= n_count;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    CFG_MASTER_UID:     r_master_uid <= i_cfg_wdata;
                    CFG_SYS_CONFIGURED: r_sys_cfg    <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pend_idx  <= n_pend_idx;
        r_is_toggle <= n_is_toggle;
        r_tag       <= n_tag;
        r_status    <= n_status;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_count  <= r_count;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_TDATA_W'({ENTRY_W'(r_out_count), r_out_status});

    // checks
    `include "authorized_tag_toggle_table_unit_assert.svh"

    `ATTT_ASSERT_ALWAYS(a_count_in_range, r_count <= CNT_W'(TABLE_DEPTH), "count above depth")
    `ATTT_ASSERT_NEXT(a_fire_leaves_idle, s_fire, r_state != ST_IDLE, "request not taken up")
    `ATTT_ASSERT_IMPL(a_shift_in_table, ram_we && r_pend_vld, r_pend_idx < r_count, "bad shift")

endmodule

>>> design/attt_ram.sv
// ----------------------------------------------------------------------------
// attt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module attt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> test/authorized_tag_toggle_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// authorized_tag_toggle_table_unit_tb: self-checking bench for the tag table
// a short directed script covers reset state, refusals, lookups and clears;
// random phases under changing master settings then fill, drain and
// overflow the table; each result word is checked against the script or a local model
// ----------------------------------------------------------------------------
module authorized_tag_toggle_table_unit_tb;
    import attt_pkg::*;

    localparam int              WATCHDOG_LIMIT = 2000;
    localparam int              HOLD_CYCLES    = 150;
    localparam int              PHASES         = 12;
    localparam int              PHASE_ITEMS    = 36;
    localparam logic [UID_BITS-1:0] UID_ONES   = '1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // mode, admin_uid, tag_uid, zero pad
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // status, entry_count, zero pad

    authorized_tag_toggle_table_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // one expected result word
    typedef struct packed {
        t_status    status;
        logic [4:0] count;
    } t_reply;

    // one line of the directed script; want_* only used when typed is set
    typedef struct packed {
        logic                set_regs;
        logic [UID_BITS-1:0] reg_master_val;
        logic                reg_on_val;
        t_mode               mode;
        logic [UID_BITS-1:0] admin;
        logic [UID_BITS-1:0] tag;
        logic                typed;
        t_status             want_status;
        logic [4:0]          want_count;
    } t_script_row;

    // local copy of the table and registers
    logic [UID_BITS-1:0] tag_table [TABLE_DEPTH];
    int                  table_count;
    logic [UID_BITS-1:0] reg_master;
    logic                reg_on;

    t_reply      replies[$];
    t_script_row script[$];

    int  errors;
    int  requests_sent;
    int  replies_checked;
    int  settings_used;
    int  status_seen [9];
    bit  send_calm;
    bit  recv_calm;
    bit  hold_req;

    // clock, 2 ns period
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int draw_gap(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [UID_BITS-1:0] rand_uid();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[UID_BITS-1:0];
    endfunction

    // position of a stored tag, -1 when absent; only live slots are searched
    function automatic int slot_of(input logic [UID_BITS-1:0] uid);
        for (int i = 0; i < table_count; i++)
            if (tag_table[i] == uid)
                return i;
        return -1;
    endfunction

    // apply one request to the local table and return its result
    function automatic void apply_request(input t_mode mode,
                                          input logic [UID_BITS-1:0] admin,
                                          input logic [UID_BITS-1:0] tag,
                                          output t_reply r);
        int slot;
        slot = slot_of(tag);
        case (mode)
            MODE_TOGGLE: begin
                // refusal order: unconfigured, bad admin, master, full
                if (!reg_on)
                    r.status = STAT_UNCONF;
                else if (admin != reg_master)
                    r.status = STAT_BAD_ADMIN;
                else if (tag == reg_master)
                    r.status = STAT_MASTER;
                else if (slot >= 0) begin
                    for (int i = slot; i < table_count - 1; i++)
                        tag_table[i] = tag_table[i + 1];
                    table_count--;
                    tag_table[table_count] = '0;
                    r.status = STAT_REMOVED;
                end else if (table_count >= TABLE_DEPTH)
                    r.status = STAT_FULL;
                else begin
                    tag_table[table_count] = tag;
                    table_count++;
                    r.status = STAT_ADDED;
                end
            end
            MODE_CLEAR: begin
                // registers survive a clear
                for (int i = 0; i < TABLE_DEPTH; i++)
                    tag_table[i] = '0;
                table_count = 0;
                r.status = STAT_CLEARED;
            end
            default: begin
                // mode 3 acts as a lookup
                r.status = (slot >= 0) ? STAT_FOUND : STAT_ABSENT;
            end
        endcase
        r.count = table_count[4:0];
    endfunction

    // offer one request word, wait for the handshake, then record the result due
    task automatic issue(input t_mode mode, input logic [UID_BITS-1:0] admin,
                         input logic [UID_BITS-1:0] tag, input bit typed,
                         input t_status want_status, input logic [4:0] want_count);
        int     gap;
        t_reply r;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, tag, admin, mode};
        do @(posedge i_clk); while (!o_s_axis_tready);
        apply_request(mode, admin, tag, r);
        // typed rows carry the expected value written in the script
        if (typed) begin
            r.status = want_status;
            r.count  = want_count;
        end
        replies.push_back(r);
        requests_sent++;
    endtask

    // stop offering and wait until every outstanding result is back
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (replies.size() != 0)
            @(posedge i_clk);
    endtask

    // write both registers back to back, only while the block is idle
    task automatic program_regs(input logic [UID_BITS-1:0] master, input bit on);
        logic [CFG_DATA_W-1:0] flag_word;
        // upper bits of the flag word are junk, only bit 0 counts
        flag_word = rand_uid();
        flag_word[0] = on;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_MASTER_UID;
        i_cfg_wdata <= master;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_SYS_CONFIGURED;
        i_cfg_wdata <= flag_word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        reg_master = master;
        reg_on     = on;
        settings_used++;
    endtask

    task automatic add_row(input bit set_regs, input logic [UID_BITS-1:0] master,
                           input bit on, input t_mode mode,
                           input logic [UID_BITS-1:0] admin,
                           input logic [UID_BITS-1:0] tag, input bit typed,
                           input t_status want_status, input logic [4:0] want_count);
        t_script_row row;
        row.set_regs       = set_regs;
        row.reg_master_val = master;
        row.reg_on_val     = on;
        row.mode           = mode;
        row.admin          = admin;
        row.tag            = tag;
        row.typed          = typed;
        row.want_status    = want_status;
        row.want_count     = want_count;
        script.push_back(row);
    endtask

    // tag choice: mostly stored tags or fresh ones, now and then the extremes
    function automatic logic [UID_BITS-1:0] pick_tag(input bit fill_bias);
        int p;
        p = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            return ($urandom_range(0, 1) == 1) ? UID_ONES : '0;
        if (table_count > 0 && p < (fill_bias ? 25 : 65))
            return tag_table[$urandom_range(0, table_count - 1)];
        return rand_uid();
    endfunction

    // one phase of random requests; a fill phase leans toward new tags
    task automatic random_phase(input int n, input bit fill_bias);
        int                  r;
        t_mode               mode;
        logic [UID_BITS-1:0] admin;
        logic [UID_BITS-1:0] tag;
        for (int k = 0; k < n; k++) begin
            r     = $urandom_range(0, 99);
            mode  = MODE_TOGGLE;
            admin = reg_master;
            tag   = pick_tag(fill_bias);
            if (r < 55) begin
                // well-formed toggle
            end else if (r < 70) begin
                mode = (r % 2 == 1) ? MODE_LOOKUP : MODE_ALT_LOOKUP;
                admin = rand_uid();
            end else if (r < 72) begin
                mode  = fill_bias ? MODE_LOOKUP : MODE_CLEAR;
                admin = rand_uid();
            end else if (r < 80) begin
                // admin off by one bit, or nothing like the master
                if (r % 2 == 0)
                    admin = reg_master ^ ({{(UID_BITS - 1){1'b0}}, 1'b1}
                                          << $urandom_range(0, UID_BITS - 1));
                else
                    admin = rand_uid();
            end else if (r < 85) begin
                tag = reg_master;
            end else begin
                // noise
                mode = t_mode'($urandom_range(0, 3));
                if (fill_bias && mode == MODE_CLEAR)
                    mode = MODE_ALT_LOOKUP;
                if ($urandom_range(0, 1) == 1)
                    admin = rand_uid();
                if ($urandom_range(0, 1) == 1)
                    tag = rand_uid();
            end
            issue(mode, admin, tag, 1'b0, STAT_ADDED, 5'd0);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_reply  want;
        t_status got_status;
        logic [4:0] got_count;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_status = t_status'(o_m_axis_tdata[STATUS_W-1:0]);
            got_count  = o_m_axis_tdata[STATUS_W +: ENTRY_W];
            if (got_status < 9)
                status_seen[got_status]++;
            if (replies.size() == 0) begin
                $display("%0t: result word with nothing pending: status %0d count %0d",
                         $time, got_status, got_count);
                errors++;
            end else begin
                want = replies.pop_front();
                replies_checked++;
                if (got_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, got_status);
                    errors++;
                end
                if (got_count !== want.count) begin
                    $display("%0t: entry count mismatch: expected %0d, actual %0d",
                             $time, want.count, got_count);
                    errors++;
                end
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        i_m_axis_tready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else
                gap = draw_gap(recv_calm);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // watchdog: too long without any handshake or register write
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we || !i_rst_n)
                idle = 0;
            else
                idle++;
        end
        $display("%0t: watchdog expired, %0d results still pending", $time, replies.size());
        $display("authorized_tag_toggle_table_unit_tb NOT OK");
        $finish;
    end

    // main sequence
    initial begin
        logic [UID_BITS-1:0] master;
        bit                  on;
        t_script_row         row;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_MASTER_UID;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        errors          = 0;
        requests_sent   = 0;
        replies_checked = 0;
        settings_used   = 0;
        send_calm       = 1'b0;
        recv_calm       = 1'b0;
        hold_req        = 1'b0;
        for (int i = 0; i < 9; i++)
            status_seen[i] = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            tag_table[i] = '0;
        table_count = 0;
        reg_master  = '0;
        reg_on      = 1'b0;

        // directed script
        // after reset: unconfigured, empty table
        add_row(0, '0, 0, MODE_TOGGLE, '0, 56'd1, 1, STAT_UNCONF, 5'd0);
        add_row(0, '0, 0, MODE_LOOKUP, '0, '0, 1, STAT_ABSENT, 5'd0);
        add_row(0, '0, 0, MODE_ALT_LOOKUP, UID_ONES, UID_ONES, 1, STAT_ABSENT, 5'd0);
        add_row(0, '0, 0, MODE_CLEAR, '0, '0, 1, STAT_CLEARED, 5'd0);
        // master all ones, configured
        add_row(1, UID_ONES, 1, MODE_TOGGLE, '0, 56'd5, 1, STAT_BAD_ADMIN, 5'd0);
        add_row(0, '0, 0, MODE_TOGGLE, UID_ONES, UID_ONES, 1, STAT_MASTER, 5'd0);
        add_row(0, '0, 0, MODE_TOGGLE, UID_ONES, '0, 1, STAT_ADDED, 5'd1);
        add_row(0, '0, 0, MODE_TOGGLE, UID_ONES, 56'h80_0000_0000_0001, 1, STAT_ADDED, 5'd2);
        add_row(0, '0, 0, MODE_TOGGLE, UID_ONES, 56'h7F_FFFF_FFFF_FFFE, 1, STAT_ADDED, 5'd3);
        add_row(0, '0, 0, MODE_LOOKUP, 56'd9, '0, 1, STAT_FOUND, 5'd3);
        add_row(0, '0, 0, MODE_TOGGLE, UID_ONES - 1, '0, 1, STAT_BAD_ADMIN, 5'd3);
        // removing the first entry shifts the rest down
        add_row(0, '0, 0, MODE_TOGGLE, UID_ONES, '0, 1, STAT_REMOVED, 5'd2);
        add_row(0, '0, 0, MODE_LOOKUP, '0, '0, 1, STAT_ABSENT, 5'd2);
        add_row(0, '0, 0, MODE_ALT_LOOKUP, '0, 56'h7F_FFFF_FFFF_FFFE, 0, STAT_FOUND, 5'd0);
        add_row(0, '0, 0, MODE_TOGGLE, UID_ONES, 56'h80_0000_0000_0001, 0, STAT_REMOVED, 5'd0);
        add_row(0, '0, 0, MODE_CLEAR, '0, '0, 1, STAT_CLEARED, 5'd0);
        add_row(0, '0, 0, MODE_LOOKUP, '0, 56'h7F_FFFF_FFFF_FFFE, 1, STAT_ABSENT, 5'd0);
        // master kept but flag dropped
        add_row(1, UID_ONES, 0, MODE_TOGGLE, UID_ONES, 56'd3, 1, STAT_UNCONF, 5'd0);
        // master zero: a zero tag is the master itself
        add_row(1, '0, 1, MODE_TOGGLE, '0, '0, 1, STAT_MASTER, 5'd0);
        add_row(0, '0, 0, MODE_TOGGLE, '0, UID_ONES, 1, STAT_ADDED, 5'd1);
        add_row(0, '0, 0, MODE_LOOKUP, UID_ONES, UID_ONES, 0, STAT_FOUND, 5'd0);
        // clear ignores admin and flag, registers survive
        add_row(0, '0, 0, MODE_CLEAR, UID_ONES, UID_ONES, 1, STAT_CLEARED, 5'd0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            row = script[i];
            if (row.set_regs) begin
                settle();
                program_regs(row.reg_master_val, row.reg_on_val);
            end
            issue(row.mode, row.admin, row.tag, row.typed, row.want_status, row.want_count);
        end

        // random phases; the table carries over from phase to phase
        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p == 0)
                master = UID_ONES;
            else if (p == 1)
                master = '0;
            else
                master = rand_uid();
            on = !(p == 2 || p == 7);
            program_regs(master, on);
            // phase 4: sender flat out while the result side holds off
            // phase 5: no idling on either side
            send_calm = (p == 4 || p == 5);
            recv_calm = (p == 5);
            if (p == 4)
                hold_req = 1'b1;
            random_phase(PHASE_ITEMS, (p % 3) != 2);
        end
        send_calm = 1'b0;
        recv_calm = 1'b0;

        settle();
        // let any stray word show up
        repeat (40) @(posedge i_clk);

        $display("%0d requests, %0d settings: added %0d removed %0d found %0d absent %0d",
                 requests_sent, settings_used, status_seen[STAT_ADDED],
                 status_seen[STAT_REMOVED], status_seen[STAT_FOUND], status_seen[STAT_ABSENT]);
        $display("unconf %0d bad admin %0d master %0d full %0d cleared %0d, %0d checked",
                 status_seen[STAT_UNCONF], status_seen[STAT_BAD_ADMIN],
                 status_seen[STAT_MASTER], status_seen[STAT_FULL],
                 status_seen[STAT_CLEARED], replies_checked);
        if (errors == 0)
            $display("authorized_tag_toggle_table_unit_tb OK");
        else
            $display("authorized_tag_toggle_table_unit_tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/attt_pkg.sv
design/attt_ram.sv
design/authorized_tag_toggle_table_unit.sv
test/authorized_tag_toggle_table_unit_tb.sv
